[rtl/rmsd_pkg.sv]
package rmsd_pkg;

  localparam int COORD_W   = 20;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int SQ_W      = PROD_W - 1;
  localparam int SUM_W     = 60;
  localparam int CNT_W     = 17;
  localparam int DEV_W     = 21;
  localparam int MAX_PAIRS = 65536;
  localparam int DEV_MAX   = 1816187;

  localparam int ROOT_W     = SUM_W / 2;
  localparam int SQRT_REM_W = ROOT_W + 2;
  localparam int DIV_STEPS  = SUM_W;
  localparam int SQRT_STEPS = SUM_W / 2;
  localparam int ITER_W     = $clog2(DIV_STEPS);

  localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(MAX_PAIRS);

  typedef struct packed {
    logic capture;
    logic square;
    logic accumulate;
    logic finish;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic result_load;
  } rmsd_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } rmsd_status_t;

endpackage

[rtl/rmsd_pair_if.sv]
interface rmsd_pair_if;
  import rmsd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] first_x;
  logic signed [COORD_W-1:0] first_y;
  logic signed [COORD_W-1:0] first_z;
  logic signed [COORD_W-1:0] second_x;
  logic signed [COORD_W-1:0] second_y;
  logic signed [COORD_W-1:0] second_z;
  logic                      last_pair;

  modport source (
    output valid, first_x, first_y, first_z, second_x, second_y, second_z, last_pair,
    input  ready
  );

  modport sink (
    input  valid, first_x, first_y, first_z, second_x, second_y, second_z, last_pair,
    output ready
  );

endinterface

[rtl/rmsd_result_if.sv]
interface rmsd_result_if;
  import rmsd_pkg::*;

  logic             valid;
  logic             ready;
  logic [DEV_W-1:0] deviation;
  logic [CNT_W-1:0] pair_count;
  logic             overflow;

  modport source (
    output valid, deviation, pair_count, overflow,
    input  ready
  );

  modport sink (
    input  valid, deviation, pair_count, overflow,
    output ready
  );

endinterface

[rtl/rmsd_ctrl.sv]
module rmsd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rmsd_pkg::rmsd_status_t status,
  output rmsd_pkg::rmsd_cmd_t    cmd
);
  import rmsd_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SQUARE = 3'd1;
  localparam logic [2:0] S_ACCUM  = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_PREP   = 3'd4;
  localparam logic [2:0] S_SQRT   = 3'd5;
  localparam logic [2:0] S_WAIT   = 3'd6;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [ITER_W-1:0] iter;
  logic [ITER_W-1:0] iter_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    iter_next  = iter;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_next = S_ACCUM;
      end
      S_ACCUM: begin
        cmd.accumulate = 1'b1;
        if (status.last) begin
          cmd.finish = 1'b1;
          iter_next  = ITER_W'(DIV_STEPS - 1);
          state_next = S_DIV;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (iter == '0) begin
          state_next = S_PREP;
        end else begin
          iter_next = iter - 1'b1;
        end
      end
      S_PREP: begin
        cmd.sqrt_init = 1'b1;
        iter_next     = ITER_W'(SQRT_STEPS - 1);
        state_next    = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (iter == '0) begin
          state_next = S_WAIT;
        end else begin
          iter_next = iter - 1'b1;
        end
      end
      S_WAIT: begin
        if (status.out_free) begin
          cmd.result_load = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      iter  <= '0;
    end else begin
      state <= state_next;
      iter  <= iter_next;
    end
  end

endmodule

[rtl/rmsd_datapath.sv]
module rmsd_datapath (
  input  logic                   clk,
  input  logic                   rst,
  rmsd_pair_if.sink              pairs,
  rmsd_result_if.source          result,
  input  rmsd_pkg::rmsd_cmd_t    cmd,
  output rmsd_pkg::rmsd_status_t status
);
  import rmsd_pkg::*;

  logic signed [DIFF_W-1:0] diff_x;
  logic signed [DIFF_W-1:0] diff_y;
  logic signed [DIFF_W-1:0] diff_z;
  logic                     last_q;
  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_y;
  logic signed [PROD_W-1:0] prod_z;
  logic [SQ_W-1:0]          sq_x;
  logic [SQ_W-1:0]          sq_y;
  logic [SQ_W-1:0]          sq_z;

  logic [SUM_W-1:0] squared_sum;
  logic [CNT_W-1:0] pairs_seen;
  logic             overflowed;
  logic [SUM_W-1:0] pair_dist;
  logic             full;
  logic [SUM_W-1:0] sum_next;
  logic [CNT_W-1:0] count_next;
  logic             ovf_next;

  logic [SUM_W-1:0] div_quo;
  logic [CNT_W-1:0] div_den;
  logic [CNT_W-1:0] div_rem;
  logic [CNT_W:0]   div_shift;
  logic             div_ge;

  logic [SUM_W-1:0]      sq_val;
  logic [ROOT_W-1:0]     sq_root;
  logic [SQRT_REM_W-1:0] sq_rem;
  logic [SQRT_REM_W+1:0] sq_shift;
  logic [SQRT_REM_W+1:0] sq_trial;
  logic                  sq_ge;

  logic             out_valid;
  logic [DEV_W-1:0] out_dev;
  logic [CNT_W-1:0] out_count;
  logic             out_ovf;
  logic [CNT_W-1:0] res_count;
  logic             res_ovf;

  assign prod_x = diff_x * diff_x;
  assign prod_y = diff_y * diff_y;
  assign prod_z = diff_z * diff_z;

  assign pair_dist = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
  assign full      = (pairs_seen == COUNT_MAX);

  always_comb begin
    if (full) begin
      sum_next   = squared_sum;
      count_next = pairs_seen;
    end else begin
      sum_next   = squared_sum + pair_dist;
      count_next = pairs_seen + 1'b1;
    end
    ovf_next = overflowed | full;
  end

  assign div_shift = {div_rem, div_quo[SUM_W-1]};
  assign div_ge    = (div_shift >= {1'b0, div_den});

  assign sq_shift = {sq_rem, sq_val[SUM_W-1 -: 2]};
  assign sq_trial = {2'b00, sq_root, 2'b01};
  assign sq_ge    = (sq_shift >= sq_trial);

  assign status.last     = last_q;
  assign status.out_free = !out_valid || result.ready;

  assign result.valid      = out_valid;
  assign result.deviation  = out_dev;
  assign result.pair_count = out_count;
  assign result.overflow   = out_ovf;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      diff_x <= {pairs.first_x[COORD_W-1], pairs.first_x}
              - {pairs.second_x[COORD_W-1], pairs.second_x};
      diff_y <= {pairs.first_y[COORD_W-1], pairs.first_y}
              - {pairs.second_y[COORD_W-1], pairs.second_y};
      diff_z <= {pairs.first_z[COORD_W-1], pairs.first_z}
              - {pairs.second_z[COORD_W-1], pairs.second_z};
      last_q <= pairs.last_pair;
    end
    if (cmd.square) begin
      sq_x <= prod_x[SQ_W-1:0];
      sq_y <= prod_y[SQ_W-1:0];
      sq_z <= prod_z[SQ_W-1:0];
    end
    if (cmd.accumulate && cmd.finish) begin
      div_quo   <= sum_next;
      div_den   <= count_next;
      div_rem   <= '0;
      res_count <= count_next;
      res_ovf   <= ovf_next;
    end else if (cmd.div_step) begin
      div_quo <= {div_quo[SUM_W-2:0], div_ge};
      if (div_ge) begin
        div_rem <= CNT_W'(div_shift - {1'b0, div_den});
      end else begin
        div_rem <= div_shift[CNT_W-1:0];
      end
    end
    if (cmd.sqrt_init) begin
      sq_val  <= div_quo;
      sq_root <= '0;
      sq_rem  <= '0;
    end else if (cmd.sqrt_step) begin
      sq_val  <= {sq_val[SUM_W-3:0], 2'b00};
      sq_root <= {sq_root[ROOT_W-2:0], sq_ge};
      if (sq_ge) begin
        sq_rem <= SQRT_REM_W'(sq_shift - sq_trial);
      end else begin
        sq_rem <= sq_shift[SQRT_REM_W-1:0];
      end
    end
    if (cmd.result_load) begin
      out_dev   <= sq_root[DEV_W-1:0];
      out_count <= res_count;
      out_ovf   <= res_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      squared_sum <= '0;
      pairs_seen  <= '0;
      overflowed  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.accumulate) begin
        if (cmd.finish) begin
          squared_sum <= '0;
          pairs_seen  <= '0;
          overflowed  <= 1'b0;
        end else begin
          squared_sum <= sum_next;
          pairs_seen  <= count_next;
          overflowed  <= ovf_next;
        end
      end
      if (cmd.result_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/rmsd_of_paired_points.sv]
// Each word is handled in turn: capture differences, square, accumulate; no new word is taken meanwhile.
// A word marked last then runs a 60-step restoring divide of the sum by the count, a setup
// step, a 30-step bit-pair square root and a load of the result word into the output
// register. The load waits while the output register holds a word that is not yet taken.
// Synchronous active-high reset clears the sum, the count, the overflow flag
// and the output valid.
module rmsd_of_paired_points (
  input  logic          clk,
  input  logic          rst,
  rmsd_pair_if.sink     pairs,
  rmsd_result_if.source result
);
  import rmsd_pkg::*;

  rmsd_cmd_t    cmd;
  rmsd_status_t status;
  logic         in_ready;

  assign pairs.ready = in_ready;

  rmsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pairs.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rmsd_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .pairs  (pairs),
    .result (result),
    .cmd    (cmd),
    .status (status)
  );

endmodule

[rtl/rmsd_checker.sv]
module rmsd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [rmsd_pkg::DEV_W-1:0] deviation,
  input logic [rmsd_pkg::CNT_W-1:0] pair_count,
  input logic                       overflow
);
  import rmsd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before it was taken");

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while a word is still in work");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pair_count != '0) && (pair_count <= COUNT_MAX))
    else $error("pair count out of range");

  a_ovf_saturated: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> pair_count == COUNT_MAX)
    else $error("overflow without a saturated count");

  a_dev_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> deviation <= DEV_W'(DEV_MAX))
    else $error("deviation above its bound");

endmodule

bind rmsd_of_paired_points rmsd_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (pairs.valid),
  .in_ready   (pairs.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .deviation  (result.deviation),
  .pair_count (result.pair_count),
  .overflow   (result.overflow)
);

[verif/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rmsd_pkg::*;

  localparam int RANDOM_WORDS = 1580;
  localparam int TAIL_WORDS   = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 150;
  localparam int RUN_LIMIT    = 2_500_000;
  localparam int ROWS         = 20;

  localparam logic signed [COORD_W-1:0] C_HI = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] C_LO = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum int unsigned {MODE_SPREAD, MODE_NEAR, MODE_CORNER, MODE_TINY} coord_mode_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] fx;
    logic signed [COORD_W-1:0] fy;
    logic signed [COORD_W-1:0] fz;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] sz;
    logic                      last;
  } pair_word_t;

  typedef struct packed {
    logic [DEV_W-1:0] deviation;
    logic [CNT_W-1:0] pair_count;
    logic             overflow;
  } rmsd_word_t;

  typedef struct packed {
    pair_word_t w;
    logic       typed;
    rmsd_word_t want;
  } script_row_t;

  logic clk;
  logic rst;

  rmsd_pair_if   pair_bus ();
  rmsd_result_if res_bus ();

  rmsd_of_paired_points uut (
    .clk    (clk),
    .rst    (rst),
    .pairs  (pair_bus.sink),
    .result (res_bus.source)
  );

  logic [SUM_W-1:0] acc_sum;
  logic [CNT_W-1:0] acc_count;
  logic             acc_over;

  rmsd_word_t  rmsd_due[$];
  int          errors;
  int unsigned words_sent;
  int unsigned cycle_count;
  bit          src_idle_en;
  bit          sink_idle_en;
  bit          hold_req;

  script_row_t script [ROWS] = '{
    '{'{20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 1'b1}, 1'b1, '{21'd0, 17'd1, 1'b0}},
    '{'{20'sd1, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 1'b1}, 1'b1, '{21'd1, 17'd1, 1'b0}},
    '{'{C_HI, C_HI, C_HI, C_HI, C_HI, C_HI, 1'b1}, 1'b1, '{21'd0, 17'd1, 1'b0}},
    '{'{C_LO, C_LO, C_LO, C_LO, C_LO, C_LO, 1'b1}, 1'b1, '{21'd0, 17'd1, 1'b0}},
    '{'{C_HI, 20'sd0, 20'sd0, C_LO, 20'sd0, 20'sd0, 1'b1}, 1'b1, '{21'd1048575, 17'd1, 1'b0}},
    '{'{20'sd0, C_LO, 20'sd0, 20'sd0, C_HI, 20'sd0, 1'b1}, 1'b1, '{21'd1048575, 17'd1, 1'b0}},
    '{'{C_LO, C_LO, C_LO, C_HI, C_HI, C_HI, 1'b1}, 1'b0, '0},
    '{'{C_HI, C_LO, C_HI, C_LO, C_HI, C_LO, 1'b0}, 1'b0, '0},
    '{'{20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 1'b1}, 1'b0, '0},
    '{'{20'sd3, 20'sd4, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 1'b0}, 1'b0, '0},
    '{'{-20'sd3, 20'sd0, 20'sd4, 20'sd0, 20'sd0, 20'sd0, 1'b0}, 1'b0, '0},
    '{'{20'sd0, 20'sd0, 20'sd0, 20'sd0, -20'sd4, 20'sd3, 1'b0}, 1'b0, '0},
    '{'{20'sd10, 20'sd10, 20'sd10, 20'sd7, 20'sd14, 20'sd10, 1'b1}, 1'b1, '{21'd5, 17'd4, 1'b0}},
    '{'{20'sd1, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 1'b0}, 1'b0, '0},
    '{'{20'sd1, 20'sd1, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 1'b1}, 1'b1, '{21'd1, 17'd2, 1'b0}},
    '{'{-20'sd1, -20'sd1, -20'sd1, 20'sd0, 20'sd0, 20'sd0, 1'b0}, 1'b0, '0},
    '{'{20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 1'b1}, 1'b1, '{21'd1, 17'd2, 1'b0}},
    '{'{20'sd12345, -20'sd6789, 20'sd200, -20'sd300, 20'sd4000, -20'sd50000, 1'b1},
      1'b0, '0},
    '{'{-20'sd1, 20'sd0, 20'sd0, 20'sd0, -20'sd1, 20'sd0, 1'b1}, 1'b1, '{21'd1, 17'd1, 1'b0}},
    '{'{C_LO, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 1'b1}, 1'b1, '{21'd524288, 17'd1, 1'b0}}
  };

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned probe;
    rem   = v;
    root  = 0;
    probe = 64'h1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic bit accumulate_pair(input pair_word_t w, output rmsd_word_t r);
    longint          dx;
    longint          dy;
    longint          dz;
    longint unsigned mean;
    r = '0;
    if (acc_count < COUNT_MAX) begin
      dx = longint'($signed(w.fx)) - longint'($signed(w.sx));
      dy = longint'($signed(w.fy)) - longint'($signed(w.sy));
      dz = longint'($signed(w.fz)) - longint'($signed(w.sz));
      acc_sum   = acc_sum + SUM_W'(dx * dx + dy * dy + dz * dz);
      acc_count = acc_count + 1'b1;
    end else begin
      acc_over = 1'b1;
    end
    if (!w.last) return 1'b0;
    mean = 64'(acc_sum) / 64'(acc_count);
    r.deviation  = DEV_W'(floor_root(mean));
    r.pair_count = acc_count;
    r.overflow   = acc_over;
    acc_sum   = '0;
    acc_count = '0;
    acc_over  = 1'b0;
    return 1'b1;
  endfunction

  function automatic pair_word_t random_pair(input coord_mode_t mode, input bit last);
    pair_word_t                w;
    logic signed [COORD_W-1:0] c [6];
    for (int i = 0; i < 6; i++) begin
      case (mode)
        MODE_SPREAD: c[i] = COORD_W'($urandom);
        MODE_NEAR: begin
          if (i < 3) c[i] = COORD_W'($urandom);
          else c[i] = c[i-3] + COORD_W'($urandom_range(0, 127)) - COORD_W'(64);
        end
        MODE_CORNER: begin
          case ($urandom_range(0, 3))
            0: c[i] = C_LO;
            1: c[i] = C_HI;
            2: c[i] = '0;
            default: c[i] = '1;
          endcase
        end
        default: c[i] = COORD_W'($urandom_range(0, 511)) - COORD_W'(256);
      endcase
    end
    w = '{c[0], c[1], c[2], c[3], c[4], c[5], last};
    return w;
  endfunction

  task automatic offer_pair(input pair_word_t w, input bit typed, input rmsd_word_t want);
    rmsd_word_t r;
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      pair_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    pair_bus.valid     <= 1'b1;
    pair_bus.first_x   <= w.fx;
    pair_bus.first_y   <= w.fy;
    pair_bus.first_z   <= w.fz;
    pair_bus.second_x  <= w.sx;
    pair_bus.second_y  <= w.sy;
    pair_bus.second_z  <= w.sz;
    pair_bus.last_pair <= w.last;
    @(posedge clk);
    while (!pair_bus.ready) @(posedge clk);
    words_sent++;
    if (accumulate_pair(w, r)) rmsd_due.push_back(typed ? want : r);
  endtask

  task automatic drain();
    pair_bus.valid <= 1'b0;
    wait (rmsd_due.size() == 0 && !hold_req);
    @(posedge clk);
  endtask

  task automatic check_field(input string what, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    rmsd_word_t due;
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (rmsd_due.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual dev %0d count %0d ovf %0d",
                 $time, res_bus.deviation, res_bus.pair_count, res_bus.overflow);
        errors++;
      end else begin
        due = rmsd_due.pop_front();
        check_field("deviation", due.deviation, res_bus.deviation);
        check_field("pair_count", due.pair_count, res_bus.pair_count);
        check_field("overflow", due.overflow, res_bus.overflow);
      end
    end
  end

  initial begin : sink_side
    res_bus.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        res_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        res_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        res_bus.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int unsigned len;
    coord_mode_t mode;
    acc_sum            = '0;
    acc_count          = '0;
    acc_over           = 1'b0;
    errors             = 0;
    words_sent         = 0;
    cycle_count        = 0;
    hold_req           = 1'b0;
    src_idle_en        = 1'b1;
    sink_idle_en       = 1'b1;
    rst                = 1'b1;
    pair_bus.valid     = 1'b0;
    pair_bus.first_x   = '0;
    pair_bus.first_y   = '0;
    pair_bus.first_z   = '0;
    pair_bus.second_x  = '0;
    pair_bus.second_y  = '0;
    pair_bus.second_z  = '0;
    pair_bus.last_pair = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < ROWS; i++) offer_pair(script[i].w, script[i].typed, script[i].want);
    drain();

    // hold the result side shut while short sets keep coming
    src_idle_en = 1'b0;
    hold_req    = 1'b1;
    for (int s = 0; s < 8; s++) begin
      len = $urandom_range(1, 4);
      for (int k = 1; k <= len; k++) offer_pair(random_pair(MODE_SPREAD, k == len), 1'b0, '0);
    end
    drain();

    // random sets; drop all idling for the final stretch
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      if (words_sent + TAIL_WORDS >= RANDOM_WORDS) begin
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
      end else begin
        if ($urandom_range(0, 9) == 0) begin
          src_idle_en  = 1'($urandom_range(0, 1));
          sink_idle_en = 1'($urandom_range(0, 1));
        end
        if ($urandom_range(0, 39) == 0) drain();
      end
      case ($urandom_range(0, 19))
        0: len = $urandom_range(31, 120);
        1, 2, 3, 4, 5: len = $urandom_range(7, 30);
        default: len = $urandom_range(1, 6);
      endcase
      mode = coord_mode_t'($urandom_range(0, 3));
      for (int k = 1; k <= len; k++) offer_pair(random_pair(mode, k == len), 1'b0, '0);
    end
    drain();

    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
